// File: rtl/core/sst_pkg.sv
// Shared types and constants for the sorted set table.
// Used by sorted_set_table_unit; depends on nothing else.
package sst_pkg;

    localparam int CAPACITY  = 64;
    localparam int KEY_WIDTH = 16;

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);

    // Port widths
    localparam int OP_W     = 2;
    localparam int KEY_IN_W = 16;
    localparam int ST_W     = 3;
    localparam int POS_W    = 6;
    localparam int CNT_O_W  = 7;

    typedef logic [KEY_WIDTH-1:0] t_key;
    typedef logic [IDX_W-1:0]     t_idx;
    typedef logic [CNT_W-1:0]     t_cnt;

    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_DELETE = 2'd1;

    typedef enum logic [ST_W-1:0] {
        ST_OK       = 3'd0,
        ST_DUP      = 3'd1,
        ST_NOTFOUND = 3'd2,
        ST_FULL     = 3'd3,
        ST_EMPTY    = 3'd4
    } t_status;

endpackage

// File: rtl/core/sorted_set_table_unit.sv
// Sorted set table: ordered key store with insert, delete and search.
// Depends on sst_pkg.
//
// Usage:
//   Request channel: drive i_op and i_key with start high; the beat is taken
//   at a rising edge where busy is low. busy stays high until the answer is
//   issued.
//   Answer channel: o_status, o_position and o_count are valid for exactly
//   one cycle while o_strobe is high. The receiver cannot stall; the answer
//   is lost if not taken that cycle. A new request may be given in the same
//   cycle the answer is shown.
//   Operation: keys live in one synchronous RAM (one read, one write port).
//   A binary search finds the key's ordered slot, each probe passing through
//   S_PROBE and S_CMP, and a final S_PROBE visit decides the result. Insert
//   then moves every larger key up one slot and delete moves them down, one
//   key per cycle through the RAM; S_DRAIN then finishes the last move and,
//   for insert, S_PUT places the key.
//   Reset: synchronous, active low; the table is empty after reset. The
//   RAM is not cleared: only slots below the count are ever used.
module sorted_set_table_unit (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [sst_pkg::OP_W-1:0]   i_op,
    input  logic [sst_pkg::KEY_IN_W-1:0] i_key,
    output logic                       o_strobe,
    output logic [sst_pkg::ST_W-1:0]   o_status,
    output logic [sst_pkg::POS_W-1:0]  o_position,
    output logic [sst_pkg::CNT_O_W-1:0] o_count
);
    import sst_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_PROBE = 6'b000010,
        S_CMP   = 6'b000100,
        S_SHIFT = 6'b001000,
        S_DRAIN = 6'b010000,
        S_PUT   = 6'b100000
    } t_state;

    t_key mem [CAPACITY];

    t_state            r_state, n_state;
    logic [OP_W-1:0]   r_op;
    t_key              r_key;
    t_cnt              r_count, n_count;
    t_cnt              r_lo, n_lo;
    t_cnt              r_hi, n_hi;
    logic              r_hit, n_hit;
    t_idx              r_mid, n_mid;
    t_idx              r_sp, n_sp;
    logic              r_wv, n_wv;
    t_idx              r_wa, n_wa;
    t_key              r_rdata;
    logic              r_strobe, n_strobe;
    t_status           r_status, n_status;
    logic [POS_W-1:0]  r_pos, n_pos;

    logic              accept;
    logic [CNT_W:0]    sum;
    t_idx              mid;
    t_idx              rd_addr;
    logic              mem_we;
    t_idx              mem_wa;
    t_key              mem_wd;
    logic              is_ins;
    logic              is_del;

    assign busy   = (r_state != S_IDLE);
    assign accept = start && !busy;
    assign is_ins = (r_op == OP_INSERT);
    assign is_del = (r_op == OP_DELETE);
    assign sum    = {1'b0, r_lo} + {1'b0, r_hi};
    assign mid    = sum[IDX_W:1];

    // Read address: probe during search, shift source during moves
    assign rd_addr = (r_state == S_SHIFT) ? r_sp : mid;

    // Pending shift beat wins; key placement follows the drain, or the search when the key goes at the end
    always_comb begin
        mem_we = 1'b0;
        mem_wa = r_wa;
        mem_wd = r_rdata;
        if (r_wv) begin
            mem_we = 1'b1;
        end else if (r_state == S_PUT) begin
            mem_we = 1'b1;
            mem_wa = IDX_W'(r_lo);
            mem_wd = r_key;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        r_rdata <= mem[rd_addr];
    end

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_lo     = r_lo;
        n_hi     = r_hi;
        n_hit    = r_hit;
        n_mid    = r_mid;
        n_sp     = r_sp;
        n_wv     = 1'b0;
        n_wa     = r_wa;
        n_strobe = 1'b0;
        n_status = r_status;
        n_pos    = r_pos;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_lo    = '0;
                    n_hi    = r_count;
                    n_hit   = 1'b0;
                    n_state = S_PROBE;
                end
            end
            S_PROBE: begin
                if (r_lo < r_hi) begin
                    n_mid   = mid;
                    n_state = S_CMP;
                end else begin
                    // Search done: r_lo is the lower bound
                    n_state = S_IDLE;
                    n_pos   = '0;
                    unique case (r_op)
                        OP_INSERT: begin
                            if (r_hit) begin
                                n_strobe = 1'b1;
                                n_status = ST_DUP;
                                n_pos    = POS_W'(r_lo);
                            end else if (r_count >= CNT_W'(CAPACITY)) begin
                                n_strobe = 1'b1;
                                n_status = ST_FULL;
                            end else if (r_lo == r_count) begin
                                n_state = S_PUT;
                            end else begin
                                n_sp    = IDX_W'(r_count - 1'b1);
                                n_state = S_SHIFT;
                            end
                        end
                        OP_DELETE: begin
                            if (r_count == '0) begin
                                n_strobe = 1'b1;
                                n_status = ST_EMPTY;
                            end else if (!r_hit) begin
                                n_strobe = 1'b1;
                                n_status = ST_NOTFOUND;
                            end else if (r_lo + 1'b1 == r_count) begin
                                n_strobe = 1'b1;
                                n_status = ST_OK;
                                n_pos    = POS_W'(r_lo);
                                n_count  = r_count - 1'b1;
                            end else begin
                                n_sp    = IDX_W'(r_lo + 1'b1);
                                n_state = S_SHIFT;
                            end
                        end
                        default: begin
                            n_strobe = 1'b1;
                            if (r_hit) begin
                                n_status = ST_OK;
                                n_pos    = POS_W'(r_lo);
                            end else begin
                                n_status = ST_NOTFOUND;
                            end
                        end
                    endcase
                end
            end
            S_CMP: begin
                if (r_rdata < r_key) begin
                    n_lo = CNT_W'(r_mid) + 1'b1;
                end else begin
                    n_hi = CNT_W'(r_mid);
                end
                if (r_rdata == r_key) begin
                    n_hit = 1'b1;
                end
                n_state = S_PROBE;
            end
            S_SHIFT: begin
                // Read slot r_sp now, write it one slot over next cycle
                n_wv = 1'b1;
                if (is_ins) begin
                    n_wa = r_sp + 1'b1;
                    if (CNT_W'(r_sp) == r_lo) begin
                        n_state = S_DRAIN;
                    end else begin
                        n_sp = r_sp - 1'b1;
                    end
                end else begin
                    n_wa = r_sp - 1'b1;
                    if (CNT_W'(r_sp) + 1'b1 == r_count) begin
                        n_state = S_DRAIN;
                    end else begin
                        n_sp = r_sp + 1'b1;
                    end
                end
            end
            S_DRAIN: begin
                if (is_del) begin
                    n_strobe = 1'b1;
                    n_status = ST_OK;
                    n_pos    = POS_W'(r_lo);
                    n_count  = r_count - 1'b1;
                    n_state  = S_IDLE;
                end else begin
                    n_state = S_PUT;
                end
            end
            S_PUT: begin
                n_strobe = 1'b1;
                n_status = ST_OK;
                n_pos    = POS_W'(r_lo);
                n_count  = r_count + 1'b1;
                n_state  = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_wv     <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_wv     <= n_wv;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op  <= i_op;
            r_key <= t_key'(i_key);
        end
        r_lo     <= n_lo;
        r_hi     <= n_hi;
        r_hit    <= n_hit;
        r_mid    <= n_mid;
        r_sp     <= n_sp;
        r_wa     <= n_wa;
        r_status <= n_status;
        r_pos    <= n_pos;
    end

    assign o_strobe   = r_strobe;
    assign o_status   = r_status;
    assign o_position = r_pos;
    assign o_count    = CNT_O_W'(r_count);

    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("key count above capacity");

    a_count_with_answer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != $past(r_count)) |-> o_strobe)
        else $error("key count changed without an answer");

    a_strobe_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(busy))
        else $error("answer issued without a request in flight");

    a_no_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !mem_we)
        else $error("RAM written while idle");

endmodule
